[src/dpt_pkg.sv]
// shared types, codes and constants of the divider and programmable timer
package dpt_pkg;

   localparam int unsigned ACCUM_W      = 11;
   localparam int unsigned CTRL_ENABLE  = 2;

   localparam logic [ACCUM_W-1:0] STEP_1024 = 11'd1024;
   localparam logic [ACCUM_W-1:0] STEP_16   = 11'd16;
   localparam logic [ACCUM_W-1:0] STEP_64   = 11'd64;
   localparam logic [ACCUM_W-1:0] STEP_256  = 11'd256;

   typedef enum logic [1:0] {
      CMD_TICK  = 2'd0,
      CMD_READ  = 2'd1,
      CMD_WRITE = 2'd2,
      CMD_NONE  = 2'd3
   } cmd_type;

   typedef enum logic [1:0] {
      SEL_DIVIDER = 2'd0,
      SEL_COUNTER = 2'd1,
      SEL_RELOAD  = 2'd2,
      SEL_CONTROL = 2'd3
   } sel_type;

   typedef enum logic [1:0] {
      RATE_1024 = 2'd0,
      RATE_16   = 2'd1,
      RATE_64   = 2'd2,
      RATE_256  = 2'd3
   } rate_type;

   typedef enum logic {
      ST_IDLE = 1'b0,
      ST_STEP = 1'b1
   } state_type;

   typedef struct packed {
      logic [1:0] command;
      logic [7:0] tick_cycles;
      logic [1:0] reg_select;
      logic [7:0] write_data;
   } req_type;

   typedef struct packed {
      logic [7:0] read_data;
      logic       timer_interrupt;
   } rsp_type;

   // sequencer controls toward the datapath
   typedef struct packed {
      logic accept;
      logic run_step;
      logic finish;
   } ctrl_type;

   function automatic logic [ACCUM_W-1:0] step_size(input logic [1:0] rate);
      logic [ACCUM_W-1:0] s;
      case (rate_type'(rate))
         RATE_1024: s = STEP_1024;
         RATE_16:   s = STEP_16;
         RATE_64:   s = STEP_64;
         RATE_256:  s = STEP_256;
         default:   s = STEP_1024;
      endcase
      return s;
   endfunction

endpackage

[src/dpt_step_unit.sv]
// shared compare-subtract unit that performs one counter step per cycle
module dpt_step_unit (
   input  logic [dpt_pkg::ACCUM_W-1:0] accum,
   input  logic [dpt_pkg::ACCUM_W-1:0] step,
   input  logic [7:0]                  counter,
   input  logic [7:0]                  reload,
   output logic                        more,
   output logic [dpt_pkg::ACCUM_W-1:0] accum_next,
   output logic [7:0]                  counter_next,
   output logic                        wrap
);

   logic [dpt_pkg::ACCUM_W:0] diff;

   always_comb begin
      diff         = {1'b0, accum} - {1'b0, step};
      more         = ~diff[dpt_pkg::ACCUM_W];
      accum_next   = diff[dpt_pkg::ACCUM_W-1:0];
      wrap         = (counter == 8'hFF);
      counter_next = wrap ? reload : counter + 8'd1;
   end

endmodule

[src/dpt_ctrl.sv]
// sequencer: accepts items and walks the counter steps of a tick
module dpt_ctrl (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   input  logic              rsp_busy,
   input  logic              go_step,
   input  logic              more,
   output dpt_pkg::ctrl_type ctrl
);

   dpt_pkg::state_type state_ff;
   dpt_pkg::state_type state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= dpt_pkg::ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         dpt_pkg::ST_IDLE: begin
            if (req_valid && !rsp_busy && go_step) state_in = dpt_pkg::ST_STEP;
         end
         dpt_pkg::ST_STEP: begin
            if (!more) state_in = dpt_pkg::ST_IDLE;
         end
         default: state_in = dpt_pkg::ST_IDLE;
      endcase
   end

   always_comb begin
      ctrl = '0;
      case (state_ff)
         dpt_pkg::ST_IDLE: begin
            ctrl.accept = req_valid && !rsp_busy;
         end
         dpt_pkg::ST_STEP: begin
            ctrl.run_step = more;
            ctrl.finish   = !more;
         end
         default: ctrl = '0;
      endcase
   end

endmodule

[src/divider_and_programmable_timer.sv]
// top level: divider and programmable timer with register access items
// reads, writes and ticks with counting off give their result in the cycle after accept
// a tick with counting on runs n counter steps (at most 79, step of 16) before its result
// the steps share one compare-subtract unit, one step per cycle; no item is taken meanwhile
// throughput: one register item per cycle while the result side keeps up
// reset clears the timer registers and any pending result; counting is disabled after reset
module divider_and_programmable_timer (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_stall,
   input  dpt_pkg::req_type req_data,
   output logic             rsp_valid,
   input  logic             rsp_stall,
   output dpt_pkg::rsp_type rsp_data
);

   logic [7:0]                  div_low_ff, div_low_in;
   logic [7:0]                  div_high_ff, div_high_in;
   logic [dpt_pkg::ACCUM_W-1:0] step_accum_ff, step_accum_in;
   logic [7:0]                  counter_ff, counter_in;
   logic [7:0]                  reload_ff, reload_in;
   logic [7:0]                  control_ff, control_in;
   logic                        irq_ff, irq_in;
   logic                        rsp_valid_ff, rsp_valid_in;
   dpt_pkg::rsp_type            rsp_data_ff, rsp_data_in;

   dpt_pkg::ctrl_type           ctrl;
   logic                        rsp_busy;
   logic                        enabled;
   logic                        is_tick;
   logic                        go_step;
   logic [dpt_pkg::ACCUM_W-1:0] step;
   logic                        more;
   logic [dpt_pkg::ACCUM_W-1:0] accum_next;
   logic [7:0]                  counter_next;
   logic                        wrap;
   logic [8:0]                  div_sum;
   logic [7:0]                  rd_sel;

   assign rsp_busy  = rsp_valid_ff && rsp_stall;
   assign enabled   = control_ff[dpt_pkg::CTRL_ENABLE];
   assign is_tick   = dpt_pkg::cmd_type'(req_data.command) == dpt_pkg::CMD_TICK;
   assign go_step   = is_tick && enabled;
   assign step      = dpt_pkg::step_size(control_ff[1:0]);
   assign req_stall = !ctrl.accept;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   dpt_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .rsp_busy  (rsp_busy),
      .go_step   (go_step),
      .more      (more),
      .ctrl      (ctrl)
   );

   dpt_step_unit u_step (
      .accum        (step_accum_ff),
      .step         (step),
      .counter      (counter_ff),
      .reload       (reload_ff),
      .more         (more),
      .accum_next   (accum_next),
      .counter_next (counter_next),
      .wrap         (wrap)
   );

   always_comb begin
      case (dpt_pkg::sel_type'(req_data.reg_select))
         dpt_pkg::SEL_DIVIDER: rd_sel = div_high_ff;
         dpt_pkg::SEL_COUNTER: rd_sel = counter_ff;
         dpt_pkg::SEL_RELOAD:  rd_sel = reload_ff;
         dpt_pkg::SEL_CONTROL: rd_sel = control_ff;
         default:              rd_sel = control_ff;
      endcase
   end

   always_comb begin
      div_low_in    = div_low_ff;
      div_high_in   = div_high_ff;
      step_accum_in = step_accum_ff;
      counter_in    = counter_ff;
      reload_in     = reload_ff;
      control_in    = control_ff;
      irq_in        = irq_ff;
      rsp_valid_in  = rsp_valid_ff && rsp_stall;
      rsp_data_in   = rsp_data_ff;
      div_sum       = {1'b0, div_low_ff} + {1'b0, req_data.tick_cycles};

      if (ctrl.accept) begin
         irq_in = 1'b0;
         case (dpt_pkg::cmd_type'(req_data.command))
            dpt_pkg::CMD_TICK: begin
               div_low_in  = div_sum[7:0];
               div_high_in = div_high_ff + {7'd0, div_sum[8]};
               if (enabled) begin
                  step_accum_in = step_accum_ff + {3'd0, req_data.tick_cycles};
               end
            end
            dpt_pkg::CMD_WRITE: begin
               case (dpt_pkg::sel_type'(req_data.reg_select))
                  dpt_pkg::SEL_DIVIDER: begin
                     div_low_in  = '0;
                     div_high_in = '0;
                  end
                  dpt_pkg::SEL_COUNTER: counter_in = req_data.write_data;
                  dpt_pkg::SEL_RELOAD:  reload_in  = req_data.write_data;
                  dpt_pkg::SEL_CONTROL: control_in = req_data.write_data;
                  default:              control_in = req_data.write_data;
               endcase
            end
            default: ;
         endcase
         // every item but an enabled tick answers right away
         if (!go_step) begin
            rsp_valid_in                = 1'b1;
            rsp_data_in.timer_interrupt = 1'b0;
            rsp_data_in.read_data       =
               (dpt_pkg::cmd_type'(req_data.command) == dpt_pkg::CMD_READ) ? rd_sel : 8'd0;
         end
      end

      if (ctrl.run_step) begin
         step_accum_in = accum_next;
         counter_in    = counter_next;
         irq_in        = irq_ff || wrap;
      end

      if (ctrl.finish) begin
         rsp_valid_in                = 1'b1;
         rsp_data_in.read_data       = 8'd0;
         rsp_data_in.timer_interrupt = irq_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         div_low_ff    <= '0;
         div_high_ff   <= '0;
         step_accum_ff <= '0;
         counter_ff    <= '0;
         reload_ff     <= '0;
         control_ff    <= '0;
         irq_ff        <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         div_low_ff    <= div_low_in;
         div_high_ff   <= div_high_in;
         step_accum_ff <= step_accum_in;
         counter_ff    <= counter_in;
         reload_ff     <= reload_in;
         control_ff    <= control_in;
         irq_ff        <= irq_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_data_ff <= rsp_data_in;
   end

   // end of a step run always leaves a result behind
   a_finish_loads: assert property (@(posedge clock) disable iff (reset)
      ctrl.finish |=> rsp_valid_ff)
      else $error("finished tick left no result");

   // each step strictly lowers the accumulator
   a_step_shrinks: assert property (@(posedge clock) disable iff (reset)
      ctrl.run_step |=> step_accum_ff < $past(step_accum_ff))
      else $error("step did not lower the accumulator");

   // a step run ends only once less than one whole step is left
   a_finish_below: assert property (@(posedge clock) disable iff (reset)
      ctrl.finish |-> step_accum_ff < step)
      else $error("step run ended with a whole step pending");

   // interrupt and read data never share a result
   a_irq_no_data: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_data_ff.timer_interrupt |-> rsp_data_ff.read_data == 8'd0)
      else $error("interrupt result carries read data");

   // no item is taken while steps are still pending
   a_no_accept_busy: assert property (@(posedge clock) disable iff (reset)
      ctrl.run_step |-> !ctrl.accept && req_stall)
      else $error("item accepted during a step run");

endmodule

[tb/sv/divider_and_programmable_timer_test.sv]
// self-checking test of the divider and programmable timer through its item channels
module divider_and_programmable_timer_test;
   import dpt_pkg::*;

   localparam int IDLE_LIMIT    = 4000;
   localparam int SETTLE_CYCLES = 200;
   localparam int RANDOM_ITEMS  = 1550;
   localparam int PRINT_LIMIT   = 100;

   typedef struct {
      req_type payload;
      bit      drain_first;
   } pending_item;

   logic    clock = 1'b0;
   logic    reset = 1'b1;
   logic    req_valid = 1'b0;
   logic    req_stall;
   req_type req_data = '0;
   logic    rsp_valid;
   logic    rsp_stall = 1'b0;
   rsp_type rsp_data;

   pending_item pending[$];
   rsp_type     expected_results[$];
   bit          pause_pending = 1'b0;
   int unsigned items_taken = 0;
   int unsigned results_seen = 0;
   int unsigned mismatches = 0;

   // timer state as the test predicts it
   logic [7:0]         div_low_acc = '0;
   logic [7:0]         div_high = '0;
   logic [ACCUM_W-1:0] step_acc = '0;
   logic [7:0]         counter_val = '0;
   logic [7:0]         reload_val = '0;
   logic [7:0]         control_val = '0;

   divider_and_programmable_timer dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   function automatic rsp_type timer_response(input req_type r);
      rsp_type            res;
      logic [8:0]         div_sum;
      logic [ACCUM_W-1:0] step_len;
      res = '0;
      case (cmd_type'(r.command))
         CMD_TICK: begin
            div_sum = {1'b0, div_low_acc} + {1'b0, r.tick_cycles};
            div_low_acc = div_sum[7:0];
            div_high = div_high + {7'd0, div_sum[8]};
            if (control_val[CTRL_ENABLE]) begin
               case (rate_type'(control_val[1:0]))
                  RATE_16:  step_len = STEP_16;
                  RATE_64:  step_len = STEP_64;
                  RATE_256: step_len = STEP_256;
                  default:  step_len = STEP_1024;
               endcase
               step_acc = step_acc + ACCUM_W'(r.tick_cycles);
               while (step_acc >= step_len) begin
                  step_acc = step_acc - step_len;
                  if (counter_val == 8'hFF) begin
                     counter_val = reload_val;
                     res.timer_interrupt = 1'b1;
                  end else begin
                     counter_val = counter_val + 8'd1;
                  end
               end
            end
         end
         CMD_READ: begin
            case (sel_type'(r.reg_select))
               SEL_DIVIDER: res.read_data = div_high;
               SEL_COUNTER: res.read_data = counter_val;
               SEL_RELOAD:  res.read_data = reload_val;
               default:     res.read_data = control_val;
            endcase
         end
         CMD_WRITE: begin
            case (sel_type'(r.reg_select))
               SEL_DIVIDER: begin
                  // data is ignored, the whole divider clears
                  div_high = '0;
                  div_low_acc = '0;
               end
               SEL_COUNTER: counter_val = r.write_data;
               SEL_RELOAD:  reload_val = r.write_data;
               default:     control_val = r.write_data;
            endcase
         end
         default: ;
      endcase
      return res;
   endfunction

   // idle stretches alternate with calm runs of zero waits
   function automatic int draw_wait(inout int calm_left);
      if (calm_left > 0) begin
         calm_left--;
         return 0;
      end
      if ($urandom_range(0, 15) == 0) begin
         calm_left = $urandom_range(10, 50);
         return 0;
      end
      return $urandom_range(0, 17);
   endfunction

   task automatic report_mismatch(input string what, input int got, input int want);
      if (mismatches < PRINT_LIMIT)
         $display("mismatch at result %0d: %s got %0h want %0h", results_seen, what, got, want);
      mismatches++;
   endtask

   function automatic void put_item(cmd_type cmd, logic [7:0] cycles, sel_type sel,
                                    logic [7:0] data);
      pending_item it;
      it.payload.command = cmd;
      it.payload.tick_cycles = cycles;
      it.payload.reg_select = sel;
      it.payload.write_data = data;
      it.drain_first = pause_pending;
      pause_pending = 1'b0;
      pending.push_back(it);
   endfunction

   function automatic void put_tick(logic [7:0] cycles);
      put_item(CMD_TICK, cycles, sel_type'($urandom_range(0, 3)), 8'($urandom));
   endfunction

   function automatic void put_read(sel_type sel);
      put_item(CMD_READ, 8'($urandom), sel, 8'($urandom));
   endfunction

   function automatic void put_write(sel_type sel, logic [7:0] data);
      put_item(CMD_WRITE, 8'($urandom), sel, data);
   endfunction

   // sender
   int send_wait = 0;
   int send_calm = 0;
   always @(posedge clock) begin
      logic        next_valid;
      pending_item nxt;
      if (reset) begin
         req_valid <= 1'b0;
         send_wait = 0;
         div_low_acc = '0;
         div_high = '0;
         step_acc = '0;
         counter_val = '0;
         reload_val = '0;
         control_val = '0;
      end else begin
         next_valid = req_valid;
         if (req_valid && !req_stall) begin
            expected_results.push_back(timer_response(req_data));
            items_taken++;
            send_wait = draw_wait(send_calm);
            next_valid = 1'b0;
         end
         if (!next_valid && pending.size() != 0) begin
            if (send_wait != 0) begin
               send_wait--;
            end else if (!pending[0].drain_first || items_taken == results_seen) begin
               nxt = pending.pop_front();
               req_data <= nxt.payload;
               next_valid = 1'b1;
            end
         end
         req_valid <= next_valid;
      end
   end

   // receiver and checker
   int take_wait = 0;
   int take_calm = 0;
   always @(posedge clock) begin
      rsp_type want;
      if (reset) begin
         rsp_stall <= 1'b0;
         take_wait = 0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            results_seen <= results_seen + 1;
            if (expected_results.size() == 0) begin
               report_mismatch("item with nothing expected, read_data", rsp_data.read_data, 0);
            end else begin
               want = expected_results.pop_front();
               if (rsp_data.read_data !== want.read_data)
                  report_mismatch("read_data", rsp_data.read_data, want.read_data);
               if (rsp_data.timer_interrupt !== want.timer_interrupt)
                  report_mismatch("timer_interrupt", rsp_data.timer_interrupt,
                                  want.timer_interrupt);
            end
            take_wait = draw_wait(take_calm);
         end
         if (take_wait != 0) begin
            rsp_stall <= 1'b1;
            take_wait--;
         end else begin
            rsp_stall <= 1'b0;
         end
      end
   end

   int idle_cycles = 0;
   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
         idle_cycles <= 0;
      end else if (idle_cycles == IDLE_LIMIT) begin
         $display("watchdog: no item moved for %0d cycles", IDLE_LIMIT);
         $display("SCOREBOARD MISMATCH");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   initial begin
      int unsigned target;
      int          n;

      // registers after reset
      put_read(SEL_DIVIDER);
      put_read(SEL_COUNTER);
      put_read(SEL_RELOAD);
      put_read(SEL_CONTROL);
      put_tick(8'hFF);
      put_tick(8'h00);
      put_read(SEL_DIVIDER);
      // step of 16 from 0xff with reload 0xff: many wraps in one tick
      put_write(SEL_COUNTER, 8'hFF);
      put_write(SEL_RELOAD, 8'hFF);
      put_write(SEL_CONTROL, 8'h05);
      put_tick(8'hFF);
      put_read(SEL_COUNTER);
      // step of 1024 keeps the leftover, then a smaller step drains it on a zero tick
      put_write(SEL_CONTROL, 8'h04);
      put_tick(8'hFF);
      put_tick(8'hFF);
      put_write(SEL_CONTROL, 8'hFF);
      put_tick(8'h00);
      put_read(SEL_CONTROL);
      put_write(SEL_DIVIDER, 8'hA5);
      put_read(SEL_DIVIDER);
      // wrap into reload of zero at step of 64
      put_write(SEL_RELOAD, 8'h00);
      put_write(SEL_COUNTER, 8'hFE);
      put_write(SEL_CONTROL, 8'h06);
      put_tick(8'hC0);
      // counting off holds the counter
      put_write(SEL_CONTROL, 8'h03);
      put_tick(8'hC8);
      put_read(SEL_COUNTER);
      pause_pending = 1'b1;
      put_item(CMD_NONE, 8'hFF, SEL_CONTROL, 8'hFF);

      target = pending.size() + RANDOM_ITEMS;
      while (pending.size() < target) begin
         if ($urandom_range(0, 9) < 7) begin
            put_write(SEL_RELOAD, 8'($urandom));
            put_write(SEL_COUNTER, $urandom_range(0, 1) ? 8'($urandom_range(8'hE0, 8'hFF))
                                                        : 8'($urandom));
            put_write(SEL_CONTROL, ($urandom_range(0, 7) == 0) ? 8'($urandom)
                                                               : (8'($urandom) | 8'h04));
            n = $urandom_range(4, 16);
            repeat (n) begin
               case ($urandom_range(0, 9))
                  0: put_read(sel_type'($urandom_range(0, 3)));
                  1: put_write(SEL_DIVIDER, 8'($urandom));
                  2: put_write(SEL_CONTROL, 8'($urandom) | 8'h04);
                  default: put_tick($urandom_range(0, 1) ? 8'($urandom_range(0, 40))
                                                         : 8'($urandom));
               endcase
            end
         end else begin
            // noise: any command with any fields
            repeat ($urandom_range(1, 4))
               put_item(cmd_type'($urandom_range(0, 3)), 8'($urandom),
                        sel_type'($urandom_range(0, 3)), 8'($urandom));
         end
         if ($urandom_range(0, 49) == 0)
            pause_pending = 1'b1;
      end

      repeat (9) @(posedge clock);
      reset <= 1'b0;
      while (pending.size() != 0 || req_valid || items_taken != results_seen)
         @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (expected_results.size() != 0)
         report_mismatch("items never delivered", 0, expected_results.size());
      if (mismatches == 0)
         $display("SCOREBOARD CLEAN");
      else
         $display("SCOREBOARD MISMATCH");
      $finish;
   end

endmodule

[divider_and_programmable_timer.f]
src/dpt_pkg.sv
src/dpt_step_unit.sv
src/dpt_ctrl.sv
src/divider_and_programmable_timer.sv
tb/sv/divider_and_programmable_timer_test.sv
